[rtl/tas_pkg.sv]
// Package for the throttle average, scale and slew block: defaults, codes and types.
package tas_pkg;

  localparam int unsigned WindowSamplesDef = 16;
  localparam int unsigned AverageShiftDef  = 4;

  // An update runs when the low bits of the write index are all zero (every fourth sample)
  localparam int unsigned UpdateBits = 2;

  localparam int unsigned AdcWidth = 12;
  localparam int unsigned PwmWidth = 16;

  // Reset values of the configuration registers
  localparam logic [AdcWidth-1:0] MinAdcRst  = 12'd0;
  localparam logic [AdcWidth-1:0] MaxAdcRst  = 12'd4095;
  localparam logic [PwmWidth-1:0] MaxPwmRst  = 16'd65535;
  localparam logic [PwmWidth-1:0] SlewStepRst = 16'd16;

  typedef enum logic [1:0] {
    REG_MIN_ADC  = 2'd0,
    REG_MAX_ADC  = 2'd1,
    REG_MAX_PWM  = 2'd2,
    REG_SLEW_STEP = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_LOW  = 2'd1,
    STATUS_HIGH = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_SLEW,
    ST_RESULT
  } state_e;

endpackage

[rtl/throttle_average_scale_slew_top.sv]
// Throttle moving average, range check, scaling and slew limiter, top level.
// Sequence: a non-update item goes from idle straight to the result state, a disabled item
//   through the slew step first, and an update item walks the window memory, checks the range,
//   multiplies, runs a PW-step restoring divider and slews (DW = max(12+clog2(N), 12+shift)).
// Throughput: one item at a time; the next is taken once the result sits in the output
//   register, and the result state waits while the receiver has not taken the previous result.
// Reset (async, active low) clears control state, configuration registers and window valid bits.
module throttle_average_scale_slew_top #(
  parameter int unsigned WINDOW_SAMPLES = tas_pkg::WindowSamplesDef,
  parameter int unsigned AVERAGE_SHIFT  = tas_pkg::AverageShiftDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] adc_sample, [12] motor_disable, [13] slew_tick
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] pwm_compare, [16] compare_written,
                                     // [18:17] throttle_status
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(WINDOW_SAMPLES);       // window address
  localparam int unsigned IW  = $clog2(WINDOW_SAMPLES + 1);   // write index, holds N
  localparam int unsigned SW  = tas_pkg::AdcWidth + AW;       // window sum
  localparam int unsigned LW  = tas_pkg::AdcWidth + AVERAGE_SHIFT; // scaled limits
  localparam int unsigned DW  = (SW > LW) ? SW : LW;          // sum minus low limit
  localparam int unsigned PW  = DW + tas_pkg::PwmWidth;       // product / dividend
  localparam int unsigned CW  = $clog2(PW);                   // divider step count
  localparam int unsigned AdW = tas_pkg::AdcWidth;
  localparam int unsigned PwW = tas_pkg::PwmWidth;

  // ---------------------------------------------------------------------------
  // Configuration registers, written only while idle
  // ---------------------------------------------------------------------------
  logic [AdW-1:0] min_adc_q, max_adc_q;
  logic [PwW-1:0] max_pwm_q, slew_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_adc_q   <= tas_pkg::MinAdcRst;
      max_adc_q   <= tas_pkg::MaxAdcRst;
      max_pwm_q   <= tas_pkg::MaxPwmRst;
      slew_step_q <= tas_pkg::SlewStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tas_pkg::reg_idx_e'(cfg_index_i))
        tas_pkg::REG_MIN_ADC:   min_adc_q   <= cfg_data_i[AdW-1:0];
        tas_pkg::REG_MAX_ADC:   max_adc_q   <= cfg_data_i[AdW-1:0];
        tas_pkg::REG_MAX_PWM:   max_pwm_q   <= cfg_data_i;
        tas_pkg::REG_SLEW_STEP: slew_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------------------
  logic [AdW-1:0] in_sample;
  logic           in_disable, in_tick, in_xfer;

  assign in_sample  = s_axis_tdata[AdW-1:0];
  assign in_disable = s_axis_tdata[12];
  assign in_tick    = s_axis_tdata[13];
  assign in_xfer    = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  tas_pkg::state_e state_q, state_d;

  logic [IW-1:0]  wr_idx_q, wr_idx_d;
  logic [AW-1:0]  wr_addr;
  logic           wr_en;
  logic [AW:0]    cnt_q;          // read issue counter over the window
  logic           rd_en, rd_pend_q, rd_hit_q;
  logic [AW-1:0]  rd_addr;
  logic [AdW-1:0] rd_data_q;
  logic [WINDOW_SAMPLES-1:0] vld_q;
  logic [AdW-1:0] win_mem [WINDOW_SAMPLES];

  logic [SW-1:0]  sum_q;
  logic [DW-1:0]  sum_x, lo_x, hi_x, diff_q;
  logic [PW-1:0]  dq_q, dq_d;     // dividend bits out, quotient bits in
  logic [AdW-1:0] rem_q, rem_d, div_val;
  logic [AdW:0]   trial;
  logic           trial_ge;
  logic [CW-1:0]  step_q;

  logic           tick_q, written_q;
  tas_pkg::status_e status_q;
  logic [PwW-1:0] tgt_q, cur_q;
  logic [PwW:0]   slew_v;
  logic           slew_ok;

  logic           out_free;

  // Settings change only between items
  assign cfg_ready_o = (state_q == tas_pkg::ST_IDLE);

  // Write index wraps from N to 1; the sample at the wrap goes to entry 0
  always_comb begin
    if (wr_idx_q < IW'(WINDOW_SAMPLES)) begin
      wr_addr  = wr_idx_q[AW-1:0];
      wr_idx_d = wr_idx_q + IW'(1);
    end else begin
      wr_addr  = '0;
      wr_idx_d = IW'(1);
    end
  end

  assign wr_en   = in_xfer && !in_disable;
  assign rd_en   = (state_q == tas_pkg::ST_SUM) && (cnt_q != (AW+1)'(WINDOW_SAMPLES));
  assign rd_addr = cnt_q[AW-1:0];

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[wr_addr] <= in_sample;
    end
    if (rd_en) begin
      rd_data_q <= win_mem[rd_addr];
    end
  end

  // Per-entry valid bits stand in for the cleared window after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_q <= vld_q[rd_addr];
      end
    end
  end

  // Range check operands
  assign sum_x = DW'(sum_q);
  assign lo_x  = DW'({min_adc_q, {AVERAGE_SHIFT{1'b0}}});
  assign hi_x  = DW'({max_adc_q, {AVERAGE_SHIFT{1'b0}}});

  // Restoring divider, one quotient bit per cycle
  assign div_val  = (max_adc_q == '0) ? AdW'(1) : max_adc_q;
  assign trial    = {rem_q, dq_q[PW-1]};
  assign trial_ge = trial >= {1'b0, div_val};
  assign rem_d    = trial_ge ? AdW'(trial - {1'b0, div_val}) : trial[AdW-1:0];
  assign dq_d     = {dq_q[PW-2:0], trial_ge};

  // Slew limiter toward the target, 17 bits so an overshoot of max_pwm is visible
  always_comb begin
    if (!tick_q) begin
      slew_v = {1'b0, cur_q};
    end else if (tgt_q >= cur_q) begin
      slew_v = ((tgt_q - cur_q) > slew_step_q) ? ({1'b0, cur_q} + {1'b0, slew_step_q})
                                               : {1'b0, tgt_q};
    end else begin
      slew_v = ((cur_q - tgt_q) > slew_step_q) ? {1'b0, cur_q - slew_step_q}
                                               : {1'b0, tgt_q};
    end
  end
  assign slew_ok = slew_v <= {1'b0, max_pwm_q};

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tas_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      tas_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_disable) begin
            state_d = tas_pkg::ST_SLEW;
          end else if (wr_idx_d[tas_pkg::UpdateBits-1:0] == '0) begin
            state_d = tas_pkg::ST_SUM;
          end else begin
            state_d = tas_pkg::ST_RESULT;
          end
        end
      end
      tas_pkg::ST_SUM: begin
        if (!rd_en && !rd_pend_q) begin
          state_d = tas_pkg::ST_CHECK;
        end
      end
      tas_pkg::ST_CHECK: begin
        state_d = ((sum_x < lo_x) || (sum_x > hi_x)) ? tas_pkg::ST_SLEW : tas_pkg::ST_MUL;
      end
      tas_pkg::ST_MUL: state_d = tas_pkg::ST_DIV;
      tas_pkg::ST_DIV: begin
        if (step_q == CW'(PW - 1)) begin
          state_d = tas_pkg::ST_SLEW;
        end
      end
      tas_pkg::ST_SLEW: state_d = tas_pkg::ST_RESULT;
      tas_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = tas_pkg::ST_IDLE;
        end
      end
      default: state_d = tas_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      cur_q     <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      step_q    <= '0;
      tick_q    <= 1'b0;
      written_q <= 1'b0;
      status_q  <= tas_pkg::STATUS_OK;
    end else begin
      case (state_q)
        tas_pkg::ST_IDLE: begin
          if (in_xfer) begin
            tick_q    <= in_tick;
            written_q <= 1'b0;
            status_q  <= tas_pkg::STATUS_OK;
            cnt_q     <= '0;
            rd_pend_q <= 1'b0;
            if (!in_disable) begin
              wr_idx_q <= wr_idx_d;
            end
          end
        end
        tas_pkg::ST_SUM: begin
          rd_pend_q <= rd_en;
          if (rd_en) begin
            cnt_q <= cnt_q + (AW+1)'(1);
          end
        end
        tas_pkg::ST_CHECK: begin
          if (sum_x < lo_x) begin
            status_q <= tas_pkg::STATUS_LOW;
          end else if (sum_x > hi_x) begin
            status_q <= tas_pkg::STATUS_HIGH;
          end
        end
        tas_pkg::ST_MUL: step_q <= '0;
        tas_pkg::ST_DIV: step_q <= step_q + CW'(1);
        tas_pkg::ST_SLEW: begin
          if (slew_ok) begin
            cur_q     <= slew_v[PwW-1:0];
            written_q <= 1'b1;
          end else begin
            status_q <= tas_pkg::STATUS_HIGH;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      tas_pkg::ST_IDLE: begin
        sum_q <= '0;
        tgt_q <= '0;
      end
      tas_pkg::ST_SUM: begin
        if (rd_pend_q && rd_hit_q) begin
          sum_q <= sum_q + SW'(rd_data_q);
        end
      end
      tas_pkg::ST_CHECK: diff_q <= sum_x - lo_x;
      tas_pkg::ST_MUL: begin
        dq_q  <= PW'(diff_q) * PW'(max_pwm_q);
        rem_q <= '0;
      end
      tas_pkg::ST_DIV: begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
        if (step_q == CW'(PW - 1)) begin
          tgt_q <= dq_d[AVERAGE_SHIFT +: PwW];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [PwW-1:0] out_cmp_q;
  logic           out_wr_q;
  logic [1:0]     out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state_q == tas_pkg::ST_RESULT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == tas_pkg::ST_RESULT) && out_free) begin
      out_cmp_q <= cur_q;
      out_wr_q  <= written_q;
      out_st_q  <= status_q;
    end
  end

  assign m_axis_tdata = {5'd0, out_st_q, out_wr_q, out_cmp_q};

`ifndef NO_ASSERTIONS
  // Write index stays within 0..N
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= IW'(WINDOW_SAMPLES))
    else $error("write index beyond window");

  // Divider remainder always below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tas_pkg::ST_DIV) |-> (rem_q < div_val))
    else $error("divider remainder out of range");

  // A written compare never exceeds full scale
  a_cmp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tas_pkg::ST_SLEW) && slew_ok) |=> (cur_q <= max_pwm_q))
    else $error("compare above full scale");

  // The window is written only by an accepted, enabled item, so only while idle
  a_wr_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == tas_pkg::ST_IDLE))
    else $error("window write outside idle");

  // Result status is always one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[18:17] != 2'd3))
    else $error("invalid status code");
`endif

endmodule

[tb/throttle_average_scale_slew_top_tb.sv]
// Self-checking testbench for the throttle average, scale and slew block.
module throttle_average_scale_slew_top_tb;

  localparam int unsigned WinSamples = tas_pkg::WindowSamplesDef;
  localparam int unsigned AvgShift   = tas_pkg::AverageShiftDef;
  localparam int unsigned IdxWidth   = $clog2(WinSamples) + 1;
  // After the last result, drain for twice a bound on the time an update item takes
  localparam int unsigned DrainCycles =
    2 * (WinSamples + 12 + $clog2(WinSamples) + AvgShift + 22);
  // Cycles without any transfer before the run is declared hung
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned ItemsPerPhase = 110;
  // Receiver hold-off: start cycle and length
  localparam int unsigned HoldStart = 8000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [11:0] sample;
    logic        dis;
    logic        tick;
  } throttle_item_t;

  typedef struct packed {
    logic [15:0]      compare;
    logic             written;
    tas_pkg::status_e status;
  } pwm_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,     // checked against the predictor
    ROW_CHECKED,  // expected result typed into the row
    ROW_CFG       // load all four settings
  } row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    throttle_item_t item;
    pwm_result_t    want;
    logic [11:0]    min_adc;
    logic [11:0]    max_adc;
    logic [15:0]    max_pwm;
    logic [15:0]    step;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  tas_pkg::reg_idx_e cfg_index_i = tas_pkg::REG_MIN_ADC;
  logic [15:0]       cfg_data_i = '0;

  throttle_average_scale_slew_top #(
    .WINDOW_SAMPLES(WinSamples),
    .AVERAGE_SHIFT (AvgShift)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: settings, sample window and held compare as the block sees them
  // ---------------------------------------------------------------------------
  logic [11:0]         set_min  = tas_pkg::MinAdcRst;
  logic [11:0]         set_max  = tas_pkg::MaxAdcRst;
  logic [15:0]         set_pwm  = tas_pkg::MaxPwmRst;
  logic [15:0]         set_step = tas_pkg::SlewStepRst;
  logic [11:0]         win_store [WinSamples];
  logic [IdxWidth-1:0] win_idx = '0;
  logic [15:0]         held_compare = '0;

  initial foreach (win_store[i]) win_store[i] = '0;

  function automatic pwm_result_t predict_pwm(throttle_item_t it);
    longint unsigned sum, lo, hi, divisor, target, cur, slewed;
    logic            do_slew;
    pwm_result_t     r;
    r.compare = '0;
    r.written = 1'b0;
    r.status  = tas_pkg::STATUS_OK;
    target    = 0;
    do_slew   = 1'b0;
    if (!it.dis) begin
      // store, wrapping from the last entry back to entry 0
      if (win_idx < WinSamples) begin
        win_store[win_idx[IdxWidth-2:0]] = it.sample;
        win_idx = win_idx + IdxWidth'(1);
      end else begin
        win_store[0] = it.sample;
        win_idx = IdxWidth'(1);
      end
      // every fourth stored sample recomputes the target
      if (win_idx[tas_pkg::UpdateBits-1:0] == '0) begin
        sum = 0;
        foreach (win_store[i]) sum += 64'(win_store[i]);
        lo = 64'(set_min);
        lo = lo << AvgShift;
        hi = 64'(set_max);
        hi = hi << AvgShift;
        if (sum < lo) begin
          r.status = tas_pkg::STATUS_LOW;
        end else if (sum > hi) begin
          r.status = tas_pkg::STATUS_HIGH;
        end else begin
          divisor = (set_max == 0) ? 64'd1 : 64'(set_max);
          target = (((sum - lo) * 64'(set_pwm)) / divisor) >> AvgShift;
        end
        do_slew = 1'b1;
      end
    end else begin
      // disabled: ramp toward zero on every item with a slew tick
      do_slew = 1'b1;
    end
    if (do_slew) begin
      cur = 64'(held_compare);
      if (!it.tick) begin
        slewed = cur;
      end else if (target >= cur) begin
        slewed = (target - cur > 64'(set_step)) ? cur + 64'(set_step) : target;
      end else begin
        slewed = (cur - target > 64'(set_step)) ? cur - 64'(set_step) : target;
      end
      if (slewed <= 64'(set_pwm)) begin
        held_compare = slewed[15:0];
        r.written = 1'b1;
      end else begin
        r.status = tas_pkg::STATUS_HIGH;
      end
    end
    r.compare = held_compare;
    return r;
  endfunction

  pwm_result_t pwm_results_q [$];
  int unsigned fail_cnt = 0;

  // ---------------------------------------------------------------------------
  // Input side: bursts of transfers with random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic offer_sample(input throttle_item_t it, input logic typed,
                              input pwm_result_t typed_res);
    int unsigned gap;
    pwm_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.tick, it.dis, it.sample};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    // transfer at this edge; valid stays up for a following item
    res = predict_pwm(it);
    pwm_results_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_setting(input tas_pkg::reg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      tas_pkg::REG_MIN_ADC:   set_min  = data[11:0];
      tas_pkg::REG_MAX_ADC:   set_max  = data[11:0];
      tas_pkg::REG_MAX_PWM:   set_pwm  = data;
      tas_pkg::REG_SLEW_STEP: set_step = data;
      default: ;
    endcase
  endtask

  // Settings change only with the block idle: input dropped, all results back
  task automatic load_settings(input logic [11:0] mn, input logic [11:0] mx,
                               input logic [15:0] pwm, input logic [15:0] step);
    logic [3:0] pad_a, pad_b;
    pad_a = 4'($urandom_range(0, 15));
    pad_b = 4'($urandom_range(0, 15));
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pwm_results_q.size() != 0);
    @(posedge clk_i);
    // upper data bits of the 12-bit registers are don't-care
    write_setting(tas_pkg::REG_MIN_ADC, {pad_a, mn});
    write_setting(tas_pkg::REG_MAX_ADC, {pad_b, mx});
    write_setting(tas_pkg::REG_MAX_PWM, pwm);
    write_setting(tas_pkg::REG_SLEW_STEP, step);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern in segments, plus one long hold-off
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  int unsigned rx_seg_left = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle == HoldStart) begin
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left != 0) begin
      // sender keeps offering; the block must back up and drop tready
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_left = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 30;
          2:       rx_stall_pct = 70;
          default: rx_stall_pct = 95;
        endcase
      end
      rx_seg_left--;
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Result checking against the oldest expectation
  pwm_result_t got, want;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got.compare = m_axis_tdata[15:0];
      got.written = m_axis_tdata[16];
      got.status  = tas_pkg::status_e'(m_axis_tdata[18:17]);
      if (pwm_results_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result transfer: compare %0d written %0b status %0d",
                   got.compare, got.written, got.status);
      end else begin
        want = pwm_results_q.pop_front();
        if (got.compare !== want.compare || got.written !== want.written ||
            got.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result mismatch: compare exp %0d got %0d, written exp %0b got %0b, %s",
                     want.compare, got.compare, want.written, got.written,
                     $sformatf("status exp %0d got %0d", want.status, got.status));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [$];

  function automatic stim_row_t item_row(logic [11:0] s, logic d, logic t);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = '{sample: s, dis: d, tick: t};
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [11:0] s, logic d, logic t,
                                            logic [15:0] cmp, logic wr,
                                            tas_pkg::status_e st);
    stim_row_t r;
    r = item_row(s, d, t);
    r.kind = ROW_CHECKED;
    r.want = '{compare: cmp, written: wr, status: st};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [11:0] mn, logic [11:0] mx,
                                        logic [15:0] pwm, logic [15:0] step);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.min_adc = mn;
    r.max_adc = mx;
    r.max_pwm = pwm;
    r.step    = step;
    return r;
  endfunction

  initial begin : stimulus
    throttle_item_t it;
    logic [11:0]    mn, mx;
    logic [15:0]    pwm, step;
    int             s;
    int unsigned    level, spread, noisy_pct;

    // Directed part, reset settings first
    // first three stores are not updates: nothing written yet
    dir_rows.push_back(checked_row(12'd4095, 1'b0, 1'b1, 16'd0, 1'b0, tas_pkg::STATUS_OK));
    dir_rows.push_back(checked_row(12'd0,    1'b0, 1'b0, 16'd0, 1'b0, tas_pkg::STATUS_OK));
    dir_rows.push_back(checked_row(12'd4095, 1'b0, 1'b1, 16'd0, 1'b0, tas_pkg::STATUS_OK));
    // fourth store: first update, slews by the default step
    dir_rows.push_back(item_row(12'd4095, 1'b0, 1'b1));
    // disabled items ramp to zero, sample ignored
    dir_rows.push_back(item_row(12'hAAA, 1'b1, 1'b1));
    dir_rows.push_back(item_row(12'h555, 1'b1, 1'b0));
    // largest step; fill the window up to its last entry
    dir_rows.push_back(cfg_row(12'd0, 12'd4095, 16'd65535, 16'd65535));
    repeat (12) dir_rows.push_back(item_row(12'd4095, 1'b0, 1'b1));
    // held compare above a lowered full scale: flagged high, not written
    dir_rows.push_back(cfg_row(12'd0, 12'd4095, 16'd1000, 16'd65535));
    dir_rows.push_back(item_row(12'd0, 1'b1, 1'b0));
    dir_rows.push_back(item_row(12'd0, 1'b1, 1'b1));
    // window wrap, then an average below the minimum
    dir_rows.push_back(cfg_row(12'd4095, 12'd4095, 16'd65535, 16'd65535));
    dir_rows.push_back(checked_row(12'd0, 1'b0, 1'b1, 16'd0, 1'b0, tas_pkg::STATUS_OK));
    dir_rows.push_back(checked_row(12'd0, 1'b0, 1'b1, 16'd0, 1'b0, tas_pkg::STATUS_OK));
    dir_rows.push_back(checked_row(12'd0, 1'b0, 1'b1, 16'd0, 1'b0, tas_pkg::STATUS_OK));
    dir_rows.push_back(checked_row(12'd0, 1'b0, 1'b1, 16'd0, 1'b1, tas_pkg::STATUS_LOW));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:     load_settings(dir_rows[i].min_adc, dir_rows[i].max_adc,
                                   dir_rows[i].max_pwm, dir_rows[i].step);
        ROW_CHECKED: offer_sample(dir_rows[i].item, 1'b1, dir_rows[i].want);
        ROW_ITEM:    offer_sample(dir_rows[i].item, 1'b0, '0);
        default: ;
      endcase
    end

    // Random part: one setting per phase, samples clustered around a level
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      spread = $urandom_range(0, 200);
      noisy_pct = 30;
      case (phase)
        0: begin
          mn = 12'd0; mx = 12'd4095; pwm = 16'd65535; step = 16'd65535;
        end
        1: begin
          // zero divisor: only an all-zero window with zero minimum stays in range
          mn = 12'd0; mx = 12'd0; pwm = 16'd1; step = 16'd65535;
          spread = 0; noisy_pct = 3;
        end
        2: begin
          mn = 12'd4095; mx = 12'd4095; pwm = 16'd65535; step = 16'd0;
          spread = 0; noisy_pct = 3;
        end
        default: begin
          mn = 12'($urandom_range(0, 3000));
          mx = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'($urandom_range(mn, 4095));
          case ($urandom_range(0, 3))
            0:       pwm = 16'd65535;
            1:       pwm = 16'($urandom_range(1, 2000));
            default: pwm = 16'($urandom_range(1, 65535));
          endcase
          case ($urandom_range(0, 2))
            0:       step = 16'($urandom_range(0, 64));
            1:       step = 16'($urandom_range(0, 65535));
            default: step = 16'($urandom_range(64, 4000));
          endcase
        end
      endcase
      if (phase == 1) level = 0;
      else if (phase == 2) level = 4095;
      else level = (mn <= mx) ? $urandom_range(mn, mx) : $urandom_range(0, 4095);
      load_settings(mn, mx, pwm, step);

      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 99) >= noisy_pct) begin
          s = int'(level) + int'($urandom_range(0, 2 * spread)) - int'(spread);
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          it.sample = s[11:0];
        end else begin
          case ($urandom_range(0, 2))
            0:       it.sample = 12'd0;
            1:       it.sample = 12'd4095;
            default: it.sample = 12'($urandom_range(0, 4095));
          endcase
        end
        it.dis  = ($urandom_range(0, 9) == 0);
        it.tick = ($urandom_range(0, 9) < 7);
        offer_sample(it, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pwm_results_q.size() != 0);
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pwm_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
